// ===== rtl/core/lz77d_pkg.sv =====
// ============================================================================
// lz77d_pkg
// Shared types and constants of the LZ77 token stream decoder.
// ============================================================================
package lz77d_pkg;

    // Width of a literal or next byte
    localparam int SYM_BITS = 8;
    // Widest offset field the decoder supports
    localparam int OFF_MAX  = 16;
    // Width of a window run count and its ceiling
    localparam int RUN_W    = 4;
    localparam int RUN_CAP  = 15;

    // Decoded token handed from the bit parser to the output engine
    typedef struct packed {
        logic [OFF_MAX-1:0]  off;     // window position of the first copied byte
        logic [RUN_W-1:0]    n_win;   // window bytes to copy (already cut to the total)
        logic                sym_en;  // next byte follows the copy
        logic                done;    // this token finishes the stream
        logic [SYM_BITS-1:0] sym;     // literal or next byte
    } t_token;

endpackage

// ===== rtl/core/lz77d_ram.sv =====
// ============================================================================
// lz77d_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module lz77d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lz77d_front.sv =====
// ============================================================================
// lz77d_front
// Bit parser: takes compressed bytes, shifts their bits in MSB first, and
// turns each finished token into a queue entry. Tracks the remaining count.
// ============================================================================
module lz77d_front #(
    parameter int OFFSET_BITS = 12,
    parameter int LENGTH_BITS = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_restart,
    input  logic [31:0]             i_total,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [7:0]              i_byte,
    output logic                    o_push,
    output lz77d_pkg::t_token       o_tok,
    input  logic                    i_full
);

    localparam int SB   = lz77d_pkg::SYM_BITS;
    localparam int TOKW = 1 + OFFSET_BITS + LENGTH_BITS + SB;
    localparam int LITW = 1 + SB;
    localparam int CW   = $clog2(TOKW + 1);

    logic                          r_busy;
    logic [7:0]                    r_byte;
    logic [2:0]                    r_bit_idx;
    logic [TOKW-1:0]               r_tok;
    logic [CW-1:0]                 r_cnt;
    logic                          r_flag;
    logic [31:0]                   r_remain;

    logic                          bit_in;
    logic [TOKW-1:0]               tok_ext;
    logic [CW-1:0]                 cnt_inc;
    logic                          flag_cur;
    logic [CW-1:0]                 need;
    logic                          complete;
    logic                          step;
    logic [LENGTH_BITS-1:0]        len_raw;
    logic [OFFSET_BITS-1:0]        off_raw;
    logic [lz77d_pkg::RUN_W-1:0]   len_sat;
    logic [lz77d_pkg::RUN_W-1:0]   len_eff;
    logic [lz77d_pkg::RUN_W:0]     run_n;
    logic                          tok_done;
    logic [31:0]                   remain_next;
    logic [31:0]                   rem_after;
    logic                          accept;

    // Next bit and token assembly
    always_comb begin
        bit_in   = r_byte[7];
        tok_ext  = {r_tok[TOKW-2:0], bit_in};
        cnt_inc  = r_cnt + 1'b1;
        flag_cur = (r_cnt == '0) ? bit_in : r_flag;
        need     = flag_cur ? CW'(TOKW) : CW'(LITW);
        complete = (cnt_inc == need);
        step     = r_busy && (!complete || !i_full);
    end

    // Token fields, run length cut to the cap and to the remaining count
    always_comb begin
        len_raw  = tok_ext[SB +: LENGTH_BITS];
        off_raw  = tok_ext[SB + LENGTH_BITS +: OFFSET_BITS];
        len_sat  = (32'(len_raw) > 32'(lz77d_pkg::RUN_CAP)) ?
                   lz77d_pkg::RUN_W'(lz77d_pkg::RUN_CAP) : lz77d_pkg::RUN_W'(len_raw);
        len_eff  = flag_cur ? len_sat : '0;
        run_n    = {1'b0, len_eff} + 1'b1;
        tok_done = (r_remain <= 32'(run_n));
        remain_next = tok_done ? 32'd0 : (r_remain - 32'(run_n));
        rem_after   = (step && complete) ? remain_next : r_remain;

        o_tok.off    = lz77d_pkg::OFF_MAX'(off_raw);
        o_tok.n_win  = (r_remain < 32'(len_eff)) ? r_remain[lz77d_pkg::RUN_W-1:0] : len_eff;
        o_tok.sym_en = (r_remain > 32'(len_eff));
        o_tok.done   = tok_done;
        o_tok.sym    = tok_ext[SB-1:0];
    end

    assign o_push  = step && complete;
    assign o_ready = !r_busy || (step && (r_bit_idx == 3'd7));
    assign accept  = i_valid && o_ready;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_bit_idx <= '0;
            r_tok     <= '0;
            r_cnt     <= '0;
            r_flag    <= 1'b0;
            r_remain  <= '0;
        end else if (i_restart) begin
            r_busy    <= 1'b0;
            r_bit_idx <= '0;
            r_tok     <= '0;
            r_cnt     <= '0;
            r_flag    <= 1'b0;
            r_remain  <= i_total;
        end else begin
            if (step) begin
                if (complete) begin
                    r_tok <= '0;
                    r_cnt <= '0;
                end else begin
                    r_tok  <= tok_ext;
                    r_cnt  <= cnt_inc;
                    r_flag <= flag_cur;
                end
                r_remain <= rem_after;
            end
            // new byte; dropped at once when the stream is finished
            if (accept) begin
                r_bit_idx <= '0;
                r_busy    <= (rem_after != 32'd0);
            end else if (step) begin
                r_bit_idx <= r_bit_idx + 1'b1;
                if ((r_bit_idx == 3'd7) || (complete && tok_done)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Byte shifter (payload)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte;
        end else if (step) begin
            r_byte <= {r_byte[6:0], 1'b0};
        end
    end

endmodule

// ===== rtl/core/lz77d_tok_fifo.sv =====
// ============================================================================
// lz77d_tok_fifo
// Small token queue between the bit parser and the output engine.
// ============================================================================
module lz77d_tok_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_flush,
    input  logic              i_push,
    input  lz77d_pkg::t_token i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output lz77d_pkg::t_token o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lz77d_pkg::t_token r_mem [DEPTH];
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [CW-1:0]     r_cnt;

    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/core/lz77d_back.sv =====
// ============================================================================
// lz77d_back
// Output engine: plays tokens out one byte per cycle while its result queue
// has room, copying from the history window and writing each byte back into it.
// ============================================================================
module lz77d_back #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int OFFSET_BITS  = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic              i_empty,
    output logic              o_pop,
    input  lz77d_pkg::t_token i_tok,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_last,
    output logic              o_done
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int PW = ((OFFSET_BITS > lz77d_pkg::RUN_W) ? OFFSET_BITS : lz77d_pkg::RUN_W) + 1;
    localparam int SW = ((AW > PW) ? AW : PW) + 1;
    localparam int OQ_DEPTH = 4;
    localparam int QW = $clog2(OQ_DEPTH);

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_RUN  = 2'b10
    } t_bk_state;

    t_bk_state                   r_state;
    lz77d_pkg::t_token           r_tk;
    logic [lz77d_pkg::RUN_W-1:0] r_left;
    logic [PW-1:0]               r_pos;
    logic [AW-1:0]               r_base;
    logic [AW-1:0]               r_head;
    logic [FW-1:0]               r_fill;

    // read stage
    logic                        r_s1_valid;
    logic                        r_s1_zero;
    logic                        r_s1_lit;
    logic                        r_s1_last;
    logic                        r_s1_done;
    logic [7:0]                  r_s1_sym;

    // result queue
    logic [7:0]                  r_oq_byte [OQ_DEPTH];
    logic                        r_oq_last [OQ_DEPTH];
    logic                        r_oq_done [OQ_DEPTH];
    logic [QW-1:0]               r_oq_wp;
    logic [QW-1:0]               r_oq_rp;
    logic [QW:0]                 r_oq_cnt;

    logic [AW-1:0]               n_head;
    logic                        credit;
    logic                        issue;
    logic [SW-1:0]               pos_sum;
    logic [AW-1:0]               rd_addr;
    logic                        beyond;
    logic                        unwritten;
    logic                        is_sym;
    logic                        item_last;
    logic [7:0]                  ram_rdata;
    logic [7:0]                  wr_byte;
    logic                        oq_pop;

    // Head after the write of this cycle
    assign n_head = r_s1_valid ?
                    ((r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1) : r_head;

    // Issue control: room for one more result after the byte in flight
    always_comb begin
        credit    = (({1'b0, r_oq_cnt} + (QW + 2)'(r_s1_valid)) < (QW + 2)'(OQ_DEPTH));
        issue     = (r_state == BK_RUN) && credit;
        is_sym    = (r_left == '0);
        item_last = is_sym || ((r_left == lz77d_pkg::RUN_W'(1)) && !r_tk.sym_en);
        o_pop     = (r_state == BK_IDLE) && !i_empty;
    end

    // Window address; positions past the end or never written read as zero
    always_comb begin
        pos_sum   = SW'(r_base) + SW'(r_pos);
        rd_addr   = (pos_sum >= SW'(WINDOW_DEPTH)) ?
                    AW'(pos_sum - SW'(WINDOW_DEPTH)) : AW'(pos_sum);
        beyond    = (32'(r_pos) >= 32'(WINDOW_DEPTH));
        unwritten = (r_fill != FW'(WINDOW_DEPTH)) && (FW'(rd_addr) >= r_fill);
    end

    lz77d_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_head),
        .i_wdata (wr_byte),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign wr_byte = r_s1_lit ? r_s1_sym : (r_s1_zero ? 8'd0 : ram_rdata);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state    <= BK_IDLE;
            r_s1_valid <= 1'b0;
            r_head     <= '0;
            r_fill     <= '0;
            r_left     <= '0;
        end else begin
            r_s1_valid <= issue;
            r_head     <= n_head;
            if (r_s1_valid && (r_fill != FW'(WINDOW_DEPTH))) begin
                r_fill <= r_fill + 1'b1;
            end
            unique case (r_state)
                BK_IDLE: begin
                    if (o_pop) begin
                        r_left  <= i_tok.n_win;
                        r_state <= BK_RUN;
                    end
                end
                BK_RUN: begin
                    if (issue) begin
                        if (!is_sym) begin
                            r_left <= r_left - 1'b1;
                        end
                        if (item_last) begin
                            r_state <= BK_IDLE;
                        end
                    end
                end
                default: r_state <= BK_IDLE;
            endcase
        end
    end

    // Token and read-stage payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tk   <= i_tok;
            r_pos  <= PW'(i_tok.off);
            r_base <= n_head;
        end else if (issue) begin
            r_pos  <= r_pos + 1'b1;
        end
        if (issue) begin
            r_s1_zero <= beyond || unwritten;
            r_s1_lit  <= is_sym;
            r_s1_last <= item_last;
            r_s1_done <= item_last && r_tk.done;
            r_s1_sym  <= r_tk.sym;
        end
    end

    // Result queue
    assign oq_pop  = o_valid && i_ready;
    assign o_valid = (r_oq_cnt != '0);
    assign o_byte  = r_oq_byte[r_oq_rp];
    assign o_last  = r_oq_last[r_oq_rp];
    assign o_done  = r_oq_done[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_s1_valid) begin
                r_oq_wp <= r_oq_wp + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rp <= r_oq_rp + 1'b1;
            end
            case ({r_s1_valid, oq_pop})
                2'b10:   r_oq_cnt <= r_oq_cnt + 1'b1;
                2'b01:   r_oq_cnt <= r_oq_cnt - 1'b1;
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_oq_byte[r_oq_wp] <= wr_byte;
            r_oq_last[r_oq_wp] <= r_s1_last;
            r_oq_done[r_oq_wp] <= r_s1_done;
        end
    end

    // Checks
    a_oq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !oq_pop) |-> (r_oq_cnt < (QW + 1)'(OQ_DEPTH)))
        else $error("result queue overflow");

    a_s1_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(r_state == BK_RUN))
        else $error("window read issued outside a token");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done) |-> o_last)
        else $error("stream end flagged on a byte that is not the last of its run");

    a_restart_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_restart |=> ((r_fill == '0) && (r_head == '0)))
        else $error("window not emptied by restart");

endmodule

// ===== rtl/core/lz77_token_stream_decoder_top.sv =====
// ============================================================================
// lz77_token_stream_decoder_top
// LZ77 token stream decoder: compressed bytes in, original bytes out.
// ============================================================================
// Usage:
//   Program total_size over the APB port (address 0). The write restarts
//   decoding: the history window, the partly gathered token and the output
//   count are cleared. Write it only while the decoder is idle.
//   Compressed bytes enter on the s_axis channel; bits are parsed MSB first.
//   Decoded bytes leave on m_axis; tlast marks the final byte of each token,
//   tuser marks the byte that completes total_size.
//   After total_size bytes, further input is accepted and discarded.
// Timing:
//   The bit parser shifts in one bit per cycle, stalling on a token's last
//   bit while the token queue is full. A finished token passes a 2-entry
//   token queue; the output engine then emits one byte per cycle while the
//   result queue has room (up to 16 per token), idling between tokens.
//   Window reads use the RAM's registered read port.
// Reset and stall:
//   After reset total_size is 0 and all input is discarded. When m_axis
//   stalls, the 4-entry result queue fills, then the token queue, then
//   s_axis_tready drops.
// ============================================================================
module lz77_token_stream_decoder_top #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int OFFSET_BITS  = 12,
    parameter int LENGTH_BITS  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // compressed input: tdata[7:0] = in_byte
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,

    // decoded output: tdata[7:0] = out_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // tuser[0] = stream_done
    output logic        m_axis_tuser,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ADDR_TOTAL_SIZE = 3'd0;
    localparam int         TOKQ_DEPTH      = 2;

    logic              r_total;
    logic [31:0]       r_total_size;
    logic              cfg_wr;
    logic              fifo_full;
    logic              fifo_empty;
    logic              tok_push;
    logic              tok_pop;
    lz77d_pkg::t_token tok_in;
    lz77d_pkg::t_token tok_out;

    // Register write and read-back
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_TOTAL_SIZE);
    assign prdata = (paddr == ADDR_TOTAL_SIZE) ? r_total_size : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_size <= '0;
            r_total      <= 1'b0;
        end else begin
            r_total <= cfg_wr;
            if (cfg_wr) begin
                r_total_size <= pwdata;
            end
        end
    end

    lz77d_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_wr),
        .i_total   (pwdata),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .o_push    (tok_push),
        .o_tok     (tok_in),
        .i_full    (fifo_full)
    );

    lz77d_tok_fifo #(
        .DEPTH (TOKQ_DEPTH)
    ) u_tok_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (cfg_wr || r_total),
        .i_push  (tok_push),
        .i_data  (tok_in),
        .o_full  (fifo_full),
        .i_pop   (tok_pop),
        .o_empty (fifo_empty),
        .o_data  (tok_out)
    );

    lz77d_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_wr),
        .i_empty   (fifo_empty),
        .o_pop     (tok_pop),
        .i_tok     (tok_out),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .o_done    (m_axis_tuser)
    );

endmodule
